// ===== hw/rtl/rse_pkg.sv =====
// Package for the record store with exchange sort.
// Holds the table size, slot and tag types, command and result codes and the beat structs.
// Depends on nothing; every other file of the block imports it.
package rse_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int TAG_W    = 4;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [TAG_W-1:0]  t_tag;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SORT   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_STORED = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_SORTED = 3'd2,
        KIND_MATCH  = 3'd3,
        KIND_NONE   = 3'd4
    } t_kind;

    // The 20-byte name key, byte 0 in the top bits, so that one unsigned
    // compare of the packed key gives byte order.
    typedef struct packed {
        logic [63:0] key_first;
        logic [63:0] key_middle;
        logic [31:0] key_tail;
    } t_key;

    typedef struct packed {
        t_key               key;
        logic signed [31:0] vouchers;
        t_tag               tag;
    } t_rec;

    typedef struct packed {
        t_op                opcode;
        logic [63:0]        name_first;
        logic [63:0]        name_middle;
        logic [31:0]        name_final;
        logic signed [31:0] vouchers;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [63:0]        out_name_first;
        logic [63:0]        out_name_middle;
        logic [31:0]        out_name_final;
        logic signed [31:0] out_vouchers;
        t_tag               record_tag;
        logic               last;
    } t_result;

    // Control of the record memory, driven by the sequencer.
    typedef struct packed {
        logic  rd_en;
        t_slot rd_addr_a;
        t_slot rd_addr_b;
        logic  wr_en;
        t_slot wr_addr;
    } t_mem_ctl;

    // Tag of a slot: the slot number wrapped to the tag width.
    function automatic t_tag slot_tag(t_slot s);
        logic [SLOT_W+TAG_W-1:0] wide;
        wide = {{TAG_W{1'b0}}, s};
        return wide[TAG_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/rse_rec_mem.sv =====
// Record memory of the record store: CAPACITY records, one write port and two read ports.
// Read data is registered and holds while no read is enabled.
// Depends on rse_pkg.
module rse_rec_mem
    import rse_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_ctl i_ctl,
    input  t_rec     i_wr_data,
    output t_rec     o_rd_a,
    output t_rec     o_rd_b
);

    t_rec r_mem [CAPACITY];
    t_rec r_rd_a;
    t_rec r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a <= r_mem[i_ctl.rd_addr_a];
            r_rd_b <= r_mem[i_ctl.rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== hw/rtl/rse_key_cmp.sv =====
// Shared name key comparator of the record store, used by both sort and search.
// Gives unsigned byte-order greater-than and equality of two 20-byte keys.
// Depends on rse_pkg.
module rse_key_cmp
    import rse_pkg::*;
(
    input  t_key i_a,
    input  t_key i_b,
    output logic o_gt,
    output logic o_eq
);

    assign o_gt = (i_a > i_b);
    assign o_eq = (i_a == i_b);

endmodule

// ===== hw/rtl/record_store_exchange_sort.sv =====
// Top level of the record store: sequencer, record memory and shared key comparator.
// Loads records, sorts the table in place by exchange sort, emits it, and searches by name.
// Depends on rse_pkg, rse_rec_mem and rse_key_cmp.
//
//  Channel   | Handshake                | Payload               | Beat taken when
//  ----------+--------------------------+-----------------------+------------------------
//  command   | start in, busy out       | i_item   (t_item)     | start high, busy low
//  result    | o_strobe out             | o_result (t_result)   | every cycle o_strobe is high
//
// A load's result appears on the next cycle; busy stays low.
// A search streams its matches from one memory read port.
// A sort opens with a read in S_RD, then makes CAPACITY*(CAPACITY-1)/2 compares on the one
// comparator: a pair that stays reads the next pair at once, a pair that swaps writes slot i
// in S_CMP and slot j in S_SWP (a second write, since the memory has a single write port),
// then takes a fresh read in S_RD unless it is the final pair; then the table is emitted.
// After reset a clearing pass writes every slot with busy high.
// The receiver cannot stall: each result beat lasts exactly one cycle.
module record_store_exchange_sort
    import rse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_CMP,
        S_SWP,
        S_PRE,
        S_EMIT,
        S_SCAN
    } t_state;

    // The final beat of a search is written from S_IDLE, once r_fin is set, through the pending record.
    localparam t_slot LAST_SLOT = t_slot'(CAPACITY - 1);
    localparam t_slot LAST_I    = t_slot'(CAPACITY - 2);
    localparam t_fill FILL_CAP  = t_fill'(CAPACITY);

    t_state  r_state, n_state;
    t_slot   r_i, n_i;
    t_slot   r_j, n_j;
    t_slot   r_k, n_k;
    t_fill   r_fill, n_fill;
    t_item   r_in, n_in;
    t_rec    r_pend, n_pend;
    logic    r_pend_vld, n_pend_vld;
    logic    r_fin, n_fin;
    logic    r_strobe, n_strobe;
    t_result r_out, n_out;

    t_mem_ctl c_mem;
    t_rec     c_wr_data;
    t_rec     rd_a;
    t_rec     rd_b;
    t_key     c_in_key;
    t_key     c_cmp_b;
    logic     cmp_gt;
    logic     cmp_eq;
    logic     c_pair_done;
    t_slot    c_next_i;
    t_slot    c_next_j;
    t_slot    c_fill_slot;

    rse_rec_mem u_mem (
        .i_clk     (i_clk),
        .i_ctl     (c_mem),
        .i_wr_data (c_wr_data),
        .o_rd_a    (rd_a),
        .o_rd_b    (rd_b)
    );

    // During a search the comparator sees the slot being scanned against the
    // requested name; during the sort it sees the two slots of the current pair.
    assign c_in_key = {r_in.name_first, r_in.name_middle, r_in.name_final};
    assign c_cmp_b  = (r_state == S_SCAN) ? c_in_key : rd_b.key;

    rse_key_cmp u_cmp (
        .i_a  (rd_a.key),
        .i_b  (c_cmp_b),
        .o_gt (cmp_gt),
        .o_eq (cmp_eq)
    );

    function automatic t_result make_result(t_kind k, t_rec r, logic l);
        t_result res;
        res.kind            = k;
        res.out_name_first  = r.key.key_first;
        res.out_name_middle = r.key.key_middle;
        res.out_name_final  = r.key.key_tail;
        res.out_vouchers    = r.vouchers;
        res.record_tag      = r.tag;
        res.last            = l;
        return res;
    endfunction

    // Walk of the pair indices: j runs from i+1 to the last slot, then i moves on.
    always_comb begin
        c_pair_done = (r_j == LAST_SLOT) && (r_i == LAST_I);
        if (r_j == LAST_SLOT) begin
            c_next_i = r_i + 1'b1;
            c_next_j = r_i + 1'b1 + 1'b1;
        end else begin
            c_next_i = r_i;
            c_next_j = r_j + 1'b1;
        end
    end

    assign c_fill_slot = r_fill[SLOT_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_fill     = r_fill;
        n_in       = r_in;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_fin      = 1'b0;
        n_strobe   = 1'b0;
        n_out      = r_out;
        c_mem      = '0;
        c_wr_data  = '0;

        unique case (r_state)
            S_CLR: begin
                // Clearing pass: zero name and count, tag equal to the slot.
                c_mem.wr_en   = 1'b1;
                c_mem.wr_addr = r_k;
                c_wr_data.tag = slot_tag(r_k);
                n_k           = r_k + 1'b1;
                if (r_k == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_fin) begin
                    // Closing beat of a search: the held match, or no match at all.
                    n_strobe   = 1'b1;
                    n_pend_vld = 1'b0;
                    if (r_pend_vld) begin
                        n_out = make_result(KIND_MATCH, r_pend, 1'b1);
                    end else begin
                        n_out = make_result(KIND_NONE, '0, 1'b1);
                    end
                end
                if (start && !r_fin) begin
                    n_in = i_item;
                    unique case (i_item.opcode)
                        OP_LOAD: begin
                            n_strobe = 1'b1;
                            if (r_fill == FILL_CAP) begin
                                n_out = make_result(KIND_FULL, '0, 1'b1);
                            end else begin
                                c_mem.wr_en              = 1'b1;
                                c_mem.wr_addr            = c_fill_slot;
                                c_wr_data.key.key_first  = i_item.name_first;
                                c_wr_data.key.key_middle = i_item.name_middle;
                                c_wr_data.key.key_tail   = i_item.name_final;
                                c_wr_data.vouchers       = i_item.vouchers;
                                c_wr_data.tag            = slot_tag(c_fill_slot);
                                n_out  = make_result(KIND_STORED, c_wr_data, 1'b1);
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        OP_SORT: begin
                            n_i     = '0;
                            n_j     = t_slot'(1);
                            n_state = S_RD;
                        end
                        OP_SEARCH: begin
                            n_pend_vld = 1'b0;
                            n_state    = S_PRE;
                        end
                        OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                c_mem.rd_en     = 1'b1;
                c_mem.rd_addr_a = r_i;
                c_mem.rd_addr_b = r_j;
                n_state         = S_CMP;
            end
            S_CMP: begin
                if (cmp_gt) begin
                    // First half of a swap: slot i takes record j.
                    c_mem.wr_en   = 1'b1;
                    c_mem.wr_addr = r_i;
                    c_wr_data     = rd_b;
                    n_state       = S_SWP;
                end else if (c_pair_done) begin
                    n_state = S_PRE;
                end else begin
                    c_mem.rd_en     = 1'b1;
                    c_mem.rd_addr_a = c_next_i;
                    c_mem.rd_addr_b = c_next_j;
                    n_i             = c_next_i;
                    n_j             = c_next_j;
                end
            end
            S_SWP: begin
                // Second half of the swap; read data still holds record i.
                c_mem.wr_en   = 1'b1;
                c_mem.wr_addr = r_j;
                c_wr_data     = rd_a;
                if (c_pair_done) begin
                    n_state = S_PRE;
                end else begin
                    n_i     = c_next_i;
                    n_j     = c_next_j;
                    n_state = S_RD;
                end
            end
            S_PRE: begin
                c_mem.rd_en     = 1'b1;
                c_mem.rd_addr_a = '0;
                n_k             = '0;
                n_state         = (r_in.opcode == OP_SORT) ? S_EMIT : S_SCAN;
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_out    = make_result(KIND_SORTED, rd_a, (r_k == LAST_SLOT));
                if (r_k == LAST_SLOT) begin
                    n_state = S_IDLE;
                end else begin
                    c_mem.rd_en     = 1'b1;
                    c_mem.rd_addr_a = r_k + 1'b1;
                    n_k             = r_k + 1'b1;
                end
            end
            S_SCAN: begin
                // One match is held back so that the final one can carry last.
                if (cmp_eq) begin
                    if (r_pend_vld) begin
                        n_strobe = 1'b1;
                        n_out    = make_result(KIND_MATCH, r_pend, 1'b0);
                    end
                    n_pend     = rd_a;
                    n_pend_vld = 1'b1;
                end
                if (r_k == LAST_SLOT) begin
                    n_fin   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    c_mem.rd_en     = 1'b1;
                    c_mem.rd_addr_a = r_k + 1'b1;
                    n_k             = r_k + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        // Payload registers carry no reset.
        r_in   <= n_in;
        r_pend <= n_pend;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_fill     <= '0;
            r_pend_vld <= 1'b0;
            r_fin      <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_fill     <= n_fill;
            r_pend_vld <= n_pend_vld;
            r_fin      <= n_fin;
            r_strobe   <= n_strobe;
        end
    end

    // The closing beat of a search is still owed while r_fin is set, so the
    // block stays busy while r_fin is set as well.
    assign busy     = (r_state != S_IDLE) || r_fin;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // The fill level never passes the table size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_CAP)
        else $error("fill level beyond table size");

    // A sort pair always has i below j.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_SWP) |-> (r_i < r_j))
        else $error("sort pair out of order");

    // A no-match beat always closes its command.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == KIND_NONE) |-> o_result.last)
        else $error("no-match beat without last");

    // An accepted sort or search keeps the block busy on the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode == OP_SORT || i_item.opcode == OP_SEARCH))
        |=> busy)
        else $error("sort or search accepted but block not busy");

endmodule

// ===== tb/record_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the record store: watches the command and result channels, keeps its own
// copy of the record table and compares every result beat with the oldest one predicted.
// Depends on rse_pkg for the beat structs, the table size and the command and result codes.
module record_table_checker
    import rse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_item   i_item,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending,
    output int      o_beats
);

    t_key               name_tab [CAPACITY];
    logic signed [31:0] count_tab[CAPACITY];
    t_tag               tag_tab  [CAPACITY];
    int                 fill;
    t_result            due_beats[$];
    int                 errors;
    int                 beats;

    // A slot below zero gives the empty payload of the full and no-match beats.
    function automatic t_result beat_for(t_kind kind, int slot, logic is_last);
        t_result r;
        r      = '0;
        r.kind = kind;
        r.last = is_last;
        if (slot >= 0) begin
            r.out_name_first  = name_tab[slot].key_first;
            r.out_name_middle = name_tab[slot].key_middle;
            r.out_name_final  = name_tab[slot].key_tail;
            r.out_vouchers    = count_tab[slot];
            r.record_tag      = tag_tab[slot];
        end
        return r;
    endfunction

    function automatic void apply_command(t_item cmd);
        t_key               key;
        t_key               tmp_key;
        logic signed [31:0] tmp_count;
        t_tag               tmp_tag;
        int                 hits;
        key  = '{cmd.name_first, cmd.name_middle, cmd.name_final};
        hits = 0;
        case (cmd.opcode)
            OP_LOAD: begin
                if (fill >= CAPACITY) begin
                    due_beats.push_back(beat_for(KIND_FULL, -1, 1'b1));
                end else begin
                    name_tab[fill]  = key;
                    count_tab[fill] = cmd.vouchers;
                    tag_tab[fill]   = t_tag'(fill);
                    due_beats.push_back(beat_for(KIND_STORED, fill, 1'b1));
                    fill++;
                end
            end
            OP_SORT: begin
                for (int a = 0; a < CAPACITY - 1; a++) begin
                    for (int b = a + 1; b < CAPACITY; b++) begin
                        if (name_tab[a] > name_tab[b]) begin
                            tmp_key      = name_tab[a];
                            tmp_count    = count_tab[a];
                            tmp_tag      = tag_tab[a];
                            name_tab[a]  = name_tab[b];
                            count_tab[a] = count_tab[b];
                            tag_tab[a]   = tag_tab[b];
                            name_tab[b]  = tmp_key;
                            count_tab[b] = tmp_count;
                            tag_tab[b]   = tmp_tag;
                        end
                    end
                end
                for (int a = 0; a < CAPACITY; a++) begin
                    due_beats.push_back(beat_for(KIND_SORTED, a, a == CAPACITY - 1));
                end
            end
            OP_SEARCH: begin
                for (int a = 0; a < CAPACITY; a++) begin
                    if (name_tab[a] == key) begin
                        due_beats.push_back(beat_for(KIND_MATCH, a, 1'b0));
                        hits++;
                    end
                end
                if (hits == 0) begin
                    due_beats.push_back(beat_for(KIND_NONE, -1, 1'b1));
                end else begin
                    due_beats[due_beats.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < CAPACITY; k++) begin
                name_tab[k]  = '0;
                count_tab[k] = '0;
                tag_tab[k]   = t_tag'(k);
            end
            fill = 0;
            due_beats.delete();
        end else begin
            // Results first: a command taken at this edge cannot answer before the next one.
            if (i_strobe === 1'b1) begin
                beats++;
                if (due_beats.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, i_result);
                    errors++;
                end else begin
                    want = due_beats.pop_front();
                    check_field("kind", want.kind, i_result.kind);
                    check_field("name_first", want.out_name_first, i_result.out_name_first);
                    check_field("name_middle", want.out_name_middle,
                                i_result.out_name_middle);
                    check_field("name_final", want.out_name_final, i_result.out_name_final);
                    check_field("vouchers", want.out_vouchers, i_result.out_vouchers);
                    check_field("record_tag", want.record_tag, i_result.record_tag);
                    check_field("last", want.last, i_result.last);
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                apply_command(i_item);
            end
        end
        o_errors  = errors;
        o_pending = due_beats.size();
        o_beats   = beats;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the record store testbench: clock, reset, command stimulus and the verdict.
// Depends on rse_pkg, the block record_store_exchange_sort and record_table_checker.
module tb
    import rse_pkg::*;
();

    // Number of random commands after the directed part.
    localparam int ITEMS      = 320;
    // Cycles with neither a command nor a result beat taken before the run is abandoned.
    // The slowest correct sort still reaches its first beat well inside this limit, so it
    // leaves a wide margin, and it also covers the clearing pass after reset.
    localparam int IDLE_LIMIT = 4000;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    logic    o_strobe;
    t_item   i_item;
    t_result o_result;

    int      errors;
    int      pending;
    int      beats;
    int      stall_cycles;
    int      n_load;
    int      n_sort;
    int      n_search;
    int      n_unused;
    int      stored;
    t_key    known_keys[$];

    record_store_exchange_sort u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // The checker sees exactly what the block sees and reports a running failure count.
    record_table_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_strobe  (o_strobe),
        .i_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending),
        .o_beats   (beats)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: any beat taken on either channel counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_key random_key();
        return '{{$urandom, $urandom}, {$urandom, $urandom}, $urandom};
    endfunction

    // A name already in the table, so that searches find something; the all-zero
    // name of the unused slots until the first load.
    function automatic t_key pick_known();
        if (known_keys.size() == 0) begin
            return '0;
        end
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    // Presents one command and returns at the edge where it is taken. Start is left
    // high, so that a following command goes out without a gap unless one is made.
    task automatic send_cmd(input t_op op, input t_key key, input logic signed [31:0] v);
        i_item <= '{op, key.key_first, key.key_middle, key.key_tail, v};
        start  <= 1'b1;
        case (op)
            OP_LOAD: begin
                n_load++;
                if (stored < CAPACITY) begin
                    known_keys.push_back(key);
                    stored++;
                end
            end
            OP_SORT:   n_sort++;
            OP_SEARCH: n_search++;
            default:   n_unused++;
        endcase
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // A gap on the command side, with random content on the idle bus.
    task automatic idle(input int cycles);
        start  <= 1'b0;
        i_item <= '{t_op'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom},
                    $urandom, $urandom};
        repeat (cycles) @(posedge i_clk);
    endtask

    // Holds commands back until every predicted result beat has arrived.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        t_key               key;
        t_key               near;
        logic [159:0]       flat;
        logic signed [31:0] v;
        int                 sel;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. On the empty table every slot holds the all-zero name, so a
        // search for it matches all slots and a sort keeps the slots in tag order.
        send_cmd(OP_SEARCH, '0, 0);
        send_cmd(OP_SEARCH, random_key(), 0);
        send_cmd(OP_SORT, '0, 0);
        send_cmd(OP_NONE, random_key(), $urandom);

        // Extremes of the name and the voucher count, a duplicate name, a name with a
        // non-zero byte after a zero byte and a pair that differ only in the last bytes.
        near = '{64'h4100_0000_0000_0000, 64'h0, 32'h0000_0001};
        send_cmd(OP_LOAD, '1, 32'sh7fff_ffff);
        send_cmd(OP_LOAD, '0, 32'sh8000_0000);
        send_cmd(OP_LOAD, near, 32'sh0000_0001);
        send_cmd(OP_LOAD, '{64'h4100_0000_0000_0000, 64'h0, 32'h0}, 32'sh0);
        send_cmd(OP_LOAD, '1, -32'sd1);
        send_cmd(OP_LOAD, '{64'h8000_0000_0000_0000, 64'h0, 32'h0}, 32'sh0);
        send_cmd(OP_SEARCH, '1, 0);
        send_cmd(OP_SEARCH, near, 0);
        send_cmd(OP_SORT, '0, 0);
        send_cmd(OP_SEARCH, '0, 0);
        send_cmd(OP_NONE, '0, 0);

        // Fill the table, then one load more to see the store report full.
        while (stored < CAPACITY) begin
            send_cmd(OP_LOAD, random_key(), $urandom);
        end
        send_cmd(OP_LOAD, random_key(), $urandom);
        send_cmd(OP_SORT, '0, 0);
        drain();

        // Random part. Searches dominate, mostly for names in the table or one bit away
        // from them; loads still come, and on the full table they must all be refused.
        for (int n = 0; n < ITEMS; n++) begin
            sel = $urandom_range(99);
            v   = $urandom;
            if (sel < 25) begin
                key = ($urandom_range(3) == 0) ? pick_known() : random_key();
                send_cmd(OP_LOAD, key, v);
            end else if (sel < 40) begin
                send_cmd(OP_SORT, random_key(), v);
            end else if (sel < 92) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: key = pick_known();
                    5, 6: begin
                        flat = pick_known();
                        flat = flat ^ (160'd1 << $urandom_range(159));
                        key  = t_key'(flat);
                    end
                    7:       key = '0;
                    default: key = random_key();
                endcase
                send_cmd(OP_SEARCH, key, v);
            end else begin
                send_cmd(OP_NONE, random_key(), v);
            end

            // Halfway the sender waits for the table to answer everything; apart from that, commands
            // 100 to 179 go out back to back with no idle gaps.
            if (n == ITEMS / 2) begin
                drain();
            end else if ((n < 100 || n >= 180) && $urandom_range(99) < 9) begin
                idle($urandom_range(1, 6));
            end
        end

        drain();
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d loads, %0d sorts, %0d searches and %0d unused commands,",
                 n_load, n_sort, n_search, n_unused);
        $display("with %0d result beats checked against the predicted table.", beats);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== record_store_exchange_sort.f =====
hw/rtl/rse_pkg.sv
hw/rtl/rse_rec_mem.sv
hw/rtl/rse_key_cmp.sv
hw/rtl/record_store_exchange_sort.sv
tb/record_table_checker.sv
tb/tb.sv
